>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the projection block.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/camproj_pkg.sv
// Package for the camera perspective projection block: widths, codes, stage types.
// Depends on nothing; used by camera_perspective_project.
package camproj_pkg;

  localparam int RES_X_DEF = 640;
  localparam int RES_Y_DEF = 480;

  // Magnitude of denominator times pixel size squared.
  localparam int DMW  = 90;
  // Magnitude of numerator, focal_sq * |dot| * 2^24.
  localparam int NUMW = 113;
  // Quotient bits; the top bit flags a quotient of 2^40 or more.
  localparam int QW   = 41;
  // Width of the shifted divisor at the widest step.
  localparam int CMPW = DMW + QW - 1;
  // Width of the signed sum before clamping.
  localparam int SUMW = 42;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_CAM_X    = 3'd0,
    CFG_CAM_Y    = 3'd1,
    CFG_CAM_Z    = 3'd2,
    CFG_FORWARD  = 3'd3,
    CFG_RIGHT    = 3'd4,
    CFG_DOWN     = 3'd5,
    CFG_FOCAL_SQ = 3'd6,
    CFG_PIX_SQ   = 3'd7
  } cfg_idx_t;

  // One item inside the divider chain: both axes share the divisor.
  typedef struct packed {
    logic [NUMW-1:0] rem_x;
    logic [NUMW-1:0] rem_y;
    logic [QW-1:0]   quo_x;
    logic [QW-1:0]   quo_y;
    logic [DMW-1:0]  dmag;
    logic            dzero;
    logic            dneg;
    logic            xneg;
    logic            yneg;
    logic            xnz;
    logic            ynz;
  } div_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } axis_t;

  // Sign, offset and clamp of one coordinate after division.
  function automatic axis_t axis_out(input logic [QW-1:0] quo, input logic neg,
                                     input logic dzero, input logic numneg,
                                     input logic nz, input logic signed [SUMW-1:0] half);
    axis_t                 res;
    logic signed [SUMW-1:0] mag;
    logic signed [SUMW-1:0] sum;
    mag = $signed({2'b00, quo[QW-2:0]});
    sum = (neg ? -mag : mag) + half;
    res.sat = 1'b0;
    if (dzero) begin
      if (!nz) res.value = half[31:0];
      else     res.value = numneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (quo[QW-1]) begin
      res.value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      res.sat   = 1'b1;
    end else if (sum > SUMW'(signed'(33'sh0_7FFF_FFFF))) begin
      res.value = 32'h7FFF_FFFF;
      res.sat   = 1'b1;
    end else if (sum < -SUMW'(signed'(33'sh0_8000_0000))) begin
      res.value = 32'h8000_0000;
      res.sat   = 1'b1;
    end else begin
      res.value = sum[31:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/camera_perspective_project.sv
// Top level of the camera perspective projection: a fully pipelined datapath.
// Depends on camproj_pkg and assert_macros.svh.
//
//  channel | ports                                          | direction
//  input   | in_valid, in_stall, in_point_x/y/z             | point in
//  result  | out_valid, out_stall, out_screen_x/y, out_status | projection out
//  config  | cfg_we, cfg_index, cfg_data                    | register write
//
// Pipeline: five arithmetic stages, 41 restoring divider steps (one quotient bit
// per stage) and the output register. One item per cycle while not stalled.
// Reset is synchronous; it clears valid bits and returns the configuration
// registers to their defaults.
// A stall holds only the stages that are full; empty stages keep filling.
`include "assert_macros.svh"

module camera_perspective_project
  import camproj_pkg::*;
#(
  parameter int RES_X = RES_X_DEF,
  parameter int RES_Y = RES_Y_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic [31:0] in_point_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_screen_x,
  output logic [31:0] out_screen_y,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  localparam logic signed [SUMW-1:0] HALF_X = SUMW'(RES_X / 2) <<< 16;
  localparam logic signed [SUMW-1:0] HALF_Y = SUMW'(RES_Y / 2) <<< 16;

  // Configuration registers.
  logic [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [62:0] fwd_r, right_r, down_r;
  logic [31:0] focal_r, pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      fwd_r   <= 63'd65536;
      right_r <= 63'd137438953472;
      down_r  <= 63'd288230376151711744;
      focal_r <= 32'd65536;
      pix_r   <= 32'd16777216;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAM_X:    cam_x_r <= cfg_data[31:0];
        CFG_CAM_Y:    cam_y_r <= cfg_data[31:0];
        CFG_CAM_Z:    cam_z_r <= cfg_data[31:0];
        CFG_FORWARD:  fwd_r   <= cfg_data;
        CFG_RIGHT:    right_r <= cfg_data;
        CFG_DOWN:     down_r  <= cfg_data;
        CFG_FOCAL_SQ: focal_r <= cfg_data[31:0];
        CFG_PIX_SQ:   pix_r   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Valid bits and the ready chain, from the output back to the input.
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, out_valid_r;
  logic [QW-1:0] dv_r;
  logic [QW:0]   rdy_d;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

  assign rdy_out   = !out_valid_r || !out_stall;
  assign rdy_d[QW] = rdy_out;
  assign rdy5      = !s5_v_r || rdy_d[0];
  assign rdy4      = !s4_v_r || rdy5;
  assign rdy3      = !s3_v_r || rdy4;
  assign rdy2      = !s2_v_r || rdy3;
  assign rdy1      = !s1_v_r || rdy2;
  assign in_stall  = !rdy1;

  // Stage 1: offset from the camera, 33-bit signed.
  logic signed [32:0] wx_r, wy_r, wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (rdy1) s1_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      wx_r <= $signed({in_point_x[31], in_point_x}) - $signed({cam_x_r[31], cam_x_r});
      wy_r <= $signed({in_point_y[31], in_point_y}) - $signed({cam_y_r[31], cam_y_r});
      wz_r <= $signed({in_point_z[31], in_point_z}) - $signed({cam_z_r[31], cam_z_r});
    end
  end

  // Stage 2: nine component products, three per basis column.
  logic signed [53:0] pf_r [3];
  logic signed [53:0] pr_r [3];
  logic signed [53:0] pd_r [3];
  logic signed [32:0] w_vec [3];

  assign w_vec[0] = wx_r;
  assign w_vec[1] = wy_r;
  assign w_vec[2] = wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (rdy2) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int i = 0; i < 3; i++) begin
        pf_r[i] <= 54'(w_vec[i]) * 54'($signed(fwd_r[21*i +: 21]));
        pr_r[i] <= 54'(w_vec[i]) * 54'($signed(right_r[21*i +: 21]));
        pd_r[i] <= 54'(w_vec[i]) * 54'($signed(down_r[21*i +: 21]));
      end
    end
  end

  // Stage 3: dot products and the denominator focal_sq * 2^16 + w.forward.
  logic signed [56:0] dr_r, dd_r;
  logic signed [57:0] den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (rdy3) s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      dr_r  <= 57'(pr_r[0]) + 57'(pr_r[1]) + 57'(pr_r[2]);
      dd_r  <= 57'(pd_r[0]) + 57'(pd_r[1]) + 57'(pd_r[2]);
      den_r <= $signed({10'd0, focal_r, 16'd0}) + 58'(pf_r[0]) + 58'(pf_r[1])
               + 58'(pf_r[2]);
    end
  end

  // Stage 4: magnitudes, each split into two partial products.
  logic [57:0] den_mag;
  logic [56:0] xr_mag, yr_mag;
  logic [63:0] dlo_r, xlo_r, ylo_r;
  logic [57:0] dhi_r;
  logic [56:0] xhi_r, yhi_r;
  logic        dneg_r, xneg_r, yneg_r;

  assign den_mag = den_r[57] ? 58'(-den_r) : 58'(den_r);
  assign xr_mag  = dr_r[56] ? 57'(-dr_r) : 57'(dr_r);
  assign yr_mag  = dd_r[56] ? 57'(-dd_r) : 57'(dd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (rdy4) s4_v_r <= s3_v_r;
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      dlo_r  <= 64'(den_mag[31:0]) * 64'(pix_r);
      dhi_r  <= 58'(den_mag[57:32]) * 58'(pix_r);
      xlo_r  <= 64'(xr_mag[31:0]) * 64'(focal_r);
      xhi_r  <= 57'(xr_mag[56:32]) * 57'(focal_r);
      ylo_r  <= 64'(yr_mag[31:0]) * 64'(focal_r);
      yhi_r  <= 57'(yr_mag[56:32]) * 57'(focal_r);
      dneg_r <= den_r[57];
      xneg_r <= dr_r[56];
      yneg_r <= dd_r[56];
    end
  end

  // Stage 5: assemble divisor and numerators for the divider.
  div_t s5_r;
  div_t s5_nxt;

  always_comb begin
    s5_nxt.dmag  = DMW'(dlo_r) + (DMW'(dhi_r) << 32);
    s5_nxt.rem_x = (NUMW'(xlo_r) + (NUMW'(xhi_r) << 32)) << 24;
    s5_nxt.rem_y = (NUMW'(ylo_r) + (NUMW'(yhi_r) << 32)) << 24;
    s5_nxt.quo_x = '0;
    s5_nxt.quo_y = '0;
    s5_nxt.dzero = (dlo_r == '0) && (dhi_r == '0);
    s5_nxt.dneg  = dneg_r;
    s5_nxt.xneg  = xneg_r;
    s5_nxt.yneg  = yneg_r;
    s5_nxt.xnz   = (xlo_r != '0) || (xhi_r != '0);
    s5_nxt.ynz   = (ylo_r != '0) || (yhi_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (rdy5) s5_v_r <= s4_v_r;
  end

  always_ff @(posedge clk) begin
    if (rdy5) s5_r <= s5_nxt;
  end

  // Restoring divider: one quotient bit per stage, most significant first.
  div_t div_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    div_t            src;
    logic            src_v;
    div_t            step_nxt;
    logic [CMPW-1:0] dsh;

    assign rdy_d[k] = !dv_r[k] || rdy_d[k+1];

    if (k == 0) begin : g_first
      assign src   = s5_r;
      assign src_v = s5_v_r;
    end else begin : g_next
      assign src   = div_r[k-1];
      assign src_v = dv_r[k-1];
    end

    assign dsh = CMPW'(src.dmag) << SH;

    always_comb begin
      step_nxt = src;
      if (CMPW'(src.rem_x) >= dsh) begin
        step_nxt.rem_x     = src.rem_x - NUMW'(dsh);
        step_nxt.quo_x[SH] = 1'b1;
      end
      if (CMPW'(src.rem_y) >= dsh) begin
        step_nxt.rem_y     = src.rem_y - NUMW'(dsh);
        step_nxt.quo_y[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k] <= 1'b0;
      else if (rdy_d[k]) dv_r[k] <= src_v;
    end

    always_ff @(posedge clk) begin
      if (rdy_d[k]) div_r[k] <= step_nxt;
    end
  end

  // Output register: sign, screen-center offset, clamp and status.
  div_t        last;
  axis_t       ax, ay;
  logic [31:0] sx_r, sy_r;
  status_t     st_r, st_nxt;

  assign last = div_r[QW-1];
  assign ax   = axis_out(last.quo_x, last.xneg ^ last.dneg, last.dzero, last.xneg,
                         last.xnz, HALF_X);
  assign ay   = axis_out(last.quo_y, last.yneg ^ last.dneg, last.dzero, last.yneg,
                         last.ynz, HALF_Y);

  always_comb begin
    if (last.dzero)           st_nxt = ST_ZERO_DEN;
    else if (ax.sat || ay.sat) st_nxt = ST_SAT;
    else                      st_nxt = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (rdy_out) out_valid_r <= dv_r[QW-1];
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      sx_r <= ax.value;
      sy_r <= ay.value;
      st_r <= st_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_screen_x = sx_r;
  assign out_screen_y = sy_r;
  assign out_status   = st_r;

  // An empty first stage never holds off the input.
  `ASSERT_IMPLIES(a_empty_accepts, clk, rst_n, !s1_v_r, !in_stall)
  // A saturated result has at least one coordinate at a limit.
  `ASSERT_IMPLIES(a_sat_at_limit, clk, rst_n, out_valid_r && (st_r == ST_SAT),
    (sx_r == 32'h7FFF_FFFF) || (sx_r == 32'h8000_0000) ||
    (sy_r == 32'h7FFF_FFFF) || (sy_r == 32'h8000_0000))
  // A full last divider stage moves into a free output register.
  `ASSERT_NEXT(a_last_moves, clk, rst_n, dv_r[QW-1] && rdy_out, out_valid_r)
  // A zero divisor ends as the zero-denominator status.
  `ASSERT_NEXT(a_zero_den, clk, rst_n, dv_r[QW-1] && rdy_out && last.dzero,
    st_r == ST_ZERO_DEN)

endmodule

>>> sim/camproj_checker.sv
// Checker for the camera perspective projection: mirrors the registers,
// predicts each projected point and compares results in order.
// Depends on camproj_pkg.
module camproj_checker
  import camproj_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  input  logic [31:0] in_point_z,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_screen_x,
  input  logic [31:0] out_screen_y,
  input  logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    status_t     st;
  } screen_pt_t;

  screen_pt_t       expected_q[$];
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [62:0]      fwd_col, right_col, down_col;
  logic [31:0]      focal_sq, pix_sq;

  assign pending = expected_q.size();

  // Signed Q4.16 component i of a packed basis column.
  function automatic longint basis_comp(input logic [62:0] word, input int i);
    logic signed [20:0] c;
    c = word[21*i +: 21];
    return longint'(c);
  endfunction

  function automatic longint dot3(input logic [62:0] word, input longint wx,
                                  input longint wy, input longint wz);
    return wx * basis_comp(word, 0) + wy * basis_comp(word, 1) + wz * basis_comp(word, 2);
  endfunction

  // One screen coordinate: scaled division, offset and clamp.
  function automatic void project_axis(input longint dr, input logic [127:0] dmag,
                                       input bit dneg, input bit dzero, input longint half,
                                       output logic [31:0] res, output bit sat);
    logic [63:0]  dr_mag;
    logic [127:0] num, quo;
    bit           neg;
    longint       v;
    dr_mag = dr < 0 ? 64'(-dr) : 64'(dr);
    num = (128'(dr_mag) * 128'(focal_sq)) << 24;
    neg = (dr < 0) != dneg;
    sat = 1'b0;
    if (dzero) begin
      if (num == 0) res = half[31:0];
      else res = dr < 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      quo = num / dmag;
      if (quo >= (128'd1 << 40)) begin
        res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sat = 1'b1;
      end else begin
        v = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
        v += half;
        if (v > 64'sd2147483647) begin
          res = 32'h7FFF_FFFF;
          sat = 1'b1;
        end else if (v < -64'sd2147483648) begin
          res = 32'h8000_0000;
          sat = 1'b1;
        end else begin
          res = v[31:0];
        end
      end
    end
  endfunction

  function automatic screen_pt_t project_point(input logic [31:0] px, input logic [31:0] py,
                                               input logic [31:0] pz);
    screen_pt_t   r;
    longint       wx, wy, wz, den;
    logic [127:0] dmag;
    bit           dzero, satx, saty;
    wx = longint'($signed(px)) - longint'(cam_x);
    wy = longint'($signed(py)) - longint'(cam_y);
    wz = longint'($signed(pz)) - longint'(cam_z);
    den = (longint'(focal_sq) <<< 16) + dot3(fwd_col, wx, wy, wz);
    dmag = 128'(den < 0 ? 64'(-den) : 64'(den)) * 128'(pix_sq);
    dzero = dmag == 0;
    project_axis(dot3(right_col, wx, wy, wz), dmag, den < 0, dzero,
                 longint'(RES_X_DEF / 2) * 65536, r.sx, satx);
    project_axis(dot3(down_col, wx, wy, wz), dmag, den < 0, dzero,
                 longint'(RES_Y_DEF / 2) * 65536, r.sy, saty);
    r.st = dzero ? ST_ZERO_DEN : ((satx || saty) ? ST_SAT : ST_OK);
    return r;
  endfunction

  // Register mirror and prediction of every accepted item.
  always @(posedge clk) begin
    if (!rst_n) begin
      cam_x     <= '0;
      cam_y     <= '0;
      cam_z     <= '0;
      fwd_col   <= 63'd65536;
      right_col <= 63'd137438953472;
      down_col  <= 63'd288230376151711744;
      focal_sq  <= 32'd65536;
      pix_sq    <= 32'd16777216;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CAM_X:    cam_x     <= cfg_data[31:0];
          CFG_CAM_Y:    cam_y     <= cfg_data[31:0];
          CFG_CAM_Z:    cam_z     <= cfg_data[31:0];
          CFG_FORWARD:  fwd_col   <= cfg_data;
          CFG_RIGHT:    right_col <= cfg_data;
          CFG_DOWN:     down_col  <= cfg_data;
          CFG_FOCAL_SQ: focal_sq  <= cfg_data[31:0];
          CFG_PIX_SQ:   pix_sq    <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_q.insert(expected_q.size(),
                          project_point(in_point_x, in_point_y, in_point_z));
    end
  end

  // Compare each accepted result with the oldest prediction.
  initial fail_count = 0;
  always @(posedge clk) begin
    screen_pt_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_screen_x !== e.sx) begin
          $error("screen_x expected %h actual %h", e.sx, out_screen_x);
          fail_count++;
        end
        if (out_screen_y !== e.sy) begin
          $error("screen_y expected %h actual %h", e.sy, out_screen_y);
          fail_count++;
        end
        if (out_status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, out_status);
          fail_count++;
        end
      end
    end
  end
endmodule

>>> sim/testbench.sv
// Top of the projection testbench: clock, reset, register setups, point
// stimulus and receiver stalls; depends on camproj_pkg, camproj_checker and the block.
module testbench;
  import camproj_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [31:0] in_point_x, in_point_y, in_point_z;
  logic        out_valid, out_stall;
  logic [31:0] out_screen_x, out_screen_y;
  logic [1:0]  out_status;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [62:0] cfg_data;
  int          fail_count, pending;
  int          sent_count;
  int          cycle_count;
  bit          hold_done;
  int          hold_left;

  camera_perspective_project dut (.*);
  camproj_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Items 400 to 549 go through with no idling on either side.
  function automatic bit idle_now();
    if (sent_count >= 400 && sent_count < 550) return 1'b0;
    return $urandom_range(99) < 38;
  endfunction

  // Receiver stall, with one long hold-off once the run is under way.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= 300) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= idle_now();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (in_stall);
    sent_count <= sent_count + 1;
  endtask

  // Coordinates: mostly a few hundred units around the origin, some full range.
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($signed($urandom_range(2 * (400 << 16))) - (400 << 16));
  endfunction

  function automatic logic [62:0] rand_basis();
    logic [62:0] w;
    for (int i = 0; i < 3; i++)
      w[21*i +: 21] = $urandom_range(3) == 0 ? 21'($urandom)
                                             : 21'($signed($urandom_range(131072)) - 65536);
    return w;
  endfunction

  // Write all registers; the block is idle when this is called.
  task automatic write_setup(input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] cz, input logic [62:0] f,
                             input logic [62:0] r, input logic [62:0] d,
                             input logic [31:0] fsq, input logic [31:0] psq);
    logic [62:0] vals[8];
    vals = '{63'(cx), 63'(cy), 63'(cz), f, r, d, 63'(fsq), 63'(psq)};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_point_x  = '0;
    in_point_y  = '0;
    in_point_z  = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    sent_count  = 0;
    cycle_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed points under the reset setup: extremes, the zero denominator
    // at x = -1, points behind the camera and on the optical axis.
    send_point(32'h0001_0000, 32'h0, 32'h0);
    send_point(32'hFFFF_0000, 32'h0, 32'h0);
    send_point(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000);
    send_point(32'hFFFF_0000, 32'h0, 32'h0);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'hFFFE_0000, 32'h0003_0000, 32'hFFFC_0000);
    send_point(32'h0009_0000, 32'h0001_8000, 32'hFFFF_4000);
    send_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    send_point(32'h0001_0000, 32'h7FFF_FFFF, 32'h0);
    send_point(32'h0002_0000, 32'h0, 32'h8000_0000);
    drain();

    // Extreme setups: camera at maximum, rest all ones; then camera at minimum, rest zero.
    write_setup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1, '1, '1);
    for (int i = 0; i < 8; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
    write_setup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0, '0, '0);
    send_point(32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 6; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();

    // Random setups with random points.
    for (int ph = 0; ph < 7; ph++) begin
      write_setup(rand_coord(), rand_coord(), rand_coord(), rand_basis(), rand_basis(),
                  rand_basis(), $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 22),
                  ph == 3 ? 32'h0 : ($urandom_range(3) == 0 ? $urandom
                                                            : $urandom_range(1 << 26, 1)));
      for (int i = 0; i < 150; i++) send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/camproj_pkg.sv
rtl/camera_perspective_project.sv
sim/camproj_checker.sv
sim/testbench.sv
